@@ hw/rtl/ddik_pkg.sv @@
// ----------------------------------------------------------------------------
// ddik_pkg
// Shared types and constants for the differential-drive wheel rate pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ddik_pkg;

  // register field widths
  localparam int HT_W    = 16;
  localparam int IR_W    = 16;
  localparam int VMAX_W  = 15;
  localparam int WMAX_W  = 15;

  // configuration channel
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // pipeline depth
  localparam int NSTAGE = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_TRACK = 4'd0,
    CFG_INV_RADIUS = 4'd1,
    CFG_V_MAX      = 4'd2,
    CFG_W_MAX      = 4'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [HT_W-1:0]   half_track;
    logic [IR_W-1:0]   inv_radius;
    logic [VMAX_W-1:0] v_max;
    logic [WMAX_W-1:0] w_max;
  } cfg_t;

  // load strobes for the limiter stages
  typedef struct packed {
    logic abs_ld;
    logic lim_ld;
  } lim_ctl_t;

  // load strobes for the wheel lane stages
  typedef struct packed {
    logic mul_ld;
    logic out_ld;
  } lane_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/ddik_if.sv @@
// ----------------------------------------------------------------------------
// ddik interfaces
// Valid/ready channels for commands, wheel rates and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddik_cmd_if #(
  parameter int DATA_WIDTH = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] v_cmd;
  logic signed [DATA_WIDTH-1:0] w_cmd;

  modport source (output valid, output v_cmd, output w_cmd, input ready);
  modport sink   (input valid, input v_cmd, input w_cmd, output ready);
endinterface

interface ddik_rate_if #(
  parameter int DATA_WIDTH = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] right_rate;
  logic signed [DATA_WIDTH-1:0] left_rate;
  logic                         rate_clipped;

  modport source (output valid, output right_rate, output left_rate,
                  output rate_clipped, input ready);
  modport sink   (input valid, input right_rate, input left_rate,
                  input rate_clipped, output ready);
endinterface

interface ddik_cfg_if import ddik_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/diff_drive_inverse_kinematics.sv @@
// ----------------------------------------------------------------------------
// diff_drive_inverse_kinematics
// Speed/turn command to right and left wheel rates with a diamond limiter.
// ----------------------------------------------------------------------------
// pipeline: the accepting edge loads the first of five register stages
// throughput: one item per cycle while rate.ready is high, every stage has
//   its own valid bit and ready ripples back only through full stages, so
//   bubbles close up
// reset: rst (sync, active high) empties the pipeline and loads the
//   registers with half_track 128, inv_radius 256, v_max 256, w_max 512
`default_nettype none

module diff_drive_inverse_kinematics import ddik_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input wire logic   clk,
  input wire logic   rst,
  ddik_cmd_if.sink   cmd,
  ddik_rate_if.source rate,
  ddik_cfg_if.sink   cfg
);

  localparam int DW = DATA_WIDTH;
  localparam int SW = DW + 17;

  // --------------------------------------------------------------------------
  // configuration registers, always writable
  // --------------------------------------------------------------------------
  cfg_t regs;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.half_track <= HT_W'(128);
      regs.inv_radius <= IR_W'(256);
      regs.v_max      <= VMAX_W'(256);
      regs.w_max      <= WMAX_W'(512);
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_HALF_TRACK: regs.half_track <= cfg.data[HT_W-1:0];
        CFG_INV_RADIUS: regs.inv_radius <= cfg.data[IR_W-1:0];
        CFG_V_MAX:      regs.v_max      <= cfg.data[VMAX_W-1:0];
        CFG_W_MAX:      regs.w_max      <= cfg.data[WMAX_W-1:0];
        default: ; // unknown index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control
  // stage 0: magnitudes, |w|*half_track and w*half_track
  // stage 1: diamond limit on speed
  // stage 2: v*2^frac +/- w*half_track, floored
  // stage 3: partial products with inv_radius
  // stage 4: recombine, floor, saturate (output register)
  // --------------------------------------------------------------------------
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;   // stage may load this cycle
  logic [NSTAGE-1:0] ld;   // stage loads a valid item

  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || rate.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
    ld[0] = en[0] && cmd.valid;
    for (int k = 1; k < NSTAGE; k++) begin
      ld[k] = en[k] && vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= cmd.valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign cmd.ready  = en[0];
  assign rate.valid = vld[NSTAGE-1];

  // --------------------------------------------------------------------------
  // limiter, stages 0 and 1
  // --------------------------------------------------------------------------
  lim_ctl_t             lim_ctl;
  logic signed [DW-1:0] v_lim;
  logic signed [SW-1:0] wt_lim;

  assign lim_ctl.abs_ld = ld[0];
  assign lim_ctl.lim_ld = ld[1];

  ddik_limiter #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_limiter (
    .clk    (clk),
    .ctl    (lim_ctl),
    .cfg    (regs),
    .v_cmd  (cmd.v_cmd),
    .w_cmd  (cmd.w_cmd),
    .v_lim  (v_lim),
    .wt_lim (wt_lim)
  );

  // --------------------------------------------------------------------------
  // wheel sums, stage 2
  // the sum of both terms fits in DATA_WIDTH+17 bits for any half_track
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] v_sh, sum_r, sum_l;
  logic signed [SW-1:0] sr, sl;

  assign v_sh  = SW'(v_lim) <<< FRAC_BITS;
  assign sum_r = v_sh + wt_lim;
  assign sum_l = v_sh - wt_lim;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      sr <= sum_r >>> FRAC_BITS;  // arithmetic shift floors
      sl <= sum_l >>> FRAC_BITS;
    end
  end

  // --------------------------------------------------------------------------
  // wheel lanes, stages 3 and 4
  // --------------------------------------------------------------------------
  lane_ctl_t lane_ctl;
  logic      clip_r, clip_l;

  assign lane_ctl.mul_ld = ld[3];
  assign lane_ctl.out_ld = ld[4];

  ddik_lane #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_lane_right (
    .clk        (clk),
    .ctl        (lane_ctl),
    .inv_radius (regs.inv_radius),
    .s          (sr),
    .rate       (rate.right_rate),
    .clip       (clip_r)
  );

  ddik_lane #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_lane_left (
    .clk        (clk),
    .ctl        (lane_ctl),
    .inv_radius (regs.inv_radius),
    .s          (sl),
    .rate       (rate.left_rate),
    .clip       (clip_l)
  );

  assign rate.rate_clipped = clip_r || clip_l;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  localparam logic [DW-1:0] SAT_HI = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SAT_LO = {1'b1, {(DW-1){1'b0}}};

  // an accepted command always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> vld[0])
    else $error("accepted item missing from first stage");

  // a clipped item carries at least one rail value
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    (rate.valid && rate.rate_clipped) |->
      (rate.right_rate == SAT_HI || rate.right_rate == SAT_LO ||
       rate.left_rate == SAT_HI || rate.left_rate == SAT_LO))
    else $error("clip flag without saturated rate");

  // a stalled sum stage keeps its data
  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[2] && !en[2]) |=> ($stable(sr) && $stable(sl)))
    else $error("stalled sum stage changed");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rate.valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

@@ hw/rtl/ddik_limiter.sv @@
// ----------------------------------------------------------------------------
// ddik_limiter
// Two stages: magnitudes and products, then the diamond speed limit.
// ----------------------------------------------------------------------------
`default_nettype none

module ddik_limiter import ddik_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                         clk,
  input  wire lim_ctl_t                     ctl,
  input  wire cfg_t                         cfg,
  input  wire logic signed [DATA_WIDTH-1:0] v_cmd,
  input  wire logic signed [DATA_WIDTH-1:0] w_cmd,
  output logic signed [DATA_WIDTH-1:0]      v_lim,
  output logic signed [DATA_WIDTH+16:0]     wt_lim
);

  localparam int DW  = DATA_WIDTH;
  localparam int TW  = DW + 16;
  localparam int LW  = DW + 17;
  localparam int MW  = (DW > WMAX_W) ? DW : WMAX_W;

  logic [DW-1:0]        av, aw;
  logic [TW-1:0]        tprod;
  logic signed [LW-1:0] wt;

  // stage 0 registers
  logic signed [DW-1:0] v_q;
  logic [DW-1:0]        av_q;
  logic [TW-1:0]        t_q;
  logic                 wcut_q;
  logic signed [LW-1:0] wt_q;

  logic                 over, t_big;
  logic [VMAX_W-1:0]    mag;
  logic [DW-1:0]        magd;
  logic signed [DW-1:0] v_lim_next;

  assign av    = v_cmd[DW-1] ? (~v_cmd + 1'b1) : v_cmd;
  assign aw    = w_cmd[DW-1] ? (~w_cmd + 1'b1) : w_cmd;
  assign tprod = aw * cfg.half_track;
  assign wt    = w_cmd * $signed({1'b0, cfg.half_track});

  always_ff @(posedge clk) begin
    if (ctl.abs_ld) begin
      v_q    <= v_cmd;
      av_q   <= av;
      t_q    <= tprod >> FRAC_BITS;
      wcut_q <= MW'(aw) >= MW'(cfg.w_max);
      wt_q   <= wt;
    end
  end

  // speed limit, direction of travel kept
  assign over  = (LW'(av_q) + LW'(t_q)) > LW'(cfg.v_max);
  assign t_big = t_q > TW'(cfg.v_max);
  assign mag   = t_big ? '0 : (cfg.v_max - t_q[VMAX_W-1:0]);
  assign magd  = DW'(mag);

  always_comb begin
    priority if (wcut_q) begin
      v_lim_next = '0;
    end else if (over) begin
      v_lim_next = v_q[DW-1] ? -$signed(magd) : $signed(magd);
    end else begin
      v_lim_next = v_q;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.lim_ld) begin
      v_lim  <= v_lim_next;
      wt_lim <= wt_q;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ddik_lane.sv @@
// ----------------------------------------------------------------------------
// ddik_lane
// One wheel: scale by inv_radius in two partial products, then saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module ddik_lane import ddik_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                         clk,
  input  wire lane_ctl_t                    ctl,
  input  wire logic [IR_W-1:0]              inv_radius,
  input  wire logic signed [DATA_WIDTH+16:0] s,
  output logic signed [DATA_WIDTH-1:0]      rate,
  output logic                              clip
);

  localparam int DW  = DATA_WIDTH;
  localparam int SW  = DW + 17;
  localparam int K   = (SW + 1) / 2;
  localparam int HW  = SW - K;
  localparam int RW  = SW + 17;

  localparam logic [DW-1:0] OUT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] OUT_MIN = {1'b1, {(DW-1){1'b0}}};

  logic [K+15:0]          p_lo;
  logic signed [HW+16:0]  p_hi;
  logic signed [RW-1:0]   full, scaled;
  logic                   in_range;

  // split product: signed high half, unsigned low half
  always_ff @(posedge clk) begin
    if (ctl.mul_ld) begin
      p_lo <= s[K-1:0] * inv_radius;
      p_hi <= $signed(s[SW-1:K]) * $signed({1'b0, inv_radius});
    end
  end

  assign full     = (RW'(p_hi) <<< K) + $signed(RW'(p_lo));
  assign scaled   = full >>> FRAC_BITS;
  assign in_range = (&scaled[RW-1:DW-1]) || !(|scaled[RW-1:DW-1]);

  always_ff @(posedge clk) begin
    if (ctl.out_ld) begin
      clip <= !in_range;
      if (in_range) begin
        rate <= scaled[DW-1:0];
      end else begin
        rate <= scaled[RW-1] ? OUT_MIN : OUT_MAX;
      end
    end
  end

endmodule

`default_nettype wire
